@@ sv/bzs_pkg.sv @@
`default_nettype none

package bzs_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF  = 10;
    localparam int DIVISIONS_RESET = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int AXES            = 3;
    localparam int CFG_INDEX_BITS  = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_START_X   = 3'd0,
        REG_START_Y   = 3'd1,
        REG_START_Z   = 3'd2,
        REG_CTRL_X    = 3'd3,
        REG_CTRL_Y    = 3'd4,
        REG_CTRL_Z    = 3'd5,
        REG_DIVISIONS = 3'd6
    } cfg_reg_t;

    // echo: return the held point untouched; step: compute a new curve point
    typedef enum logic {
        CMD_ECHO = 1'b0,
        CMD_STEP = 1'b1
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    fin;
    } cmd_ctl_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_COEF = 3'd1,
        BK_PROD = 3'd2,
        BK_ABS  = 3'd3,
        BK_DIV  = 3'd4,
        BK_SAT  = 3'd5
    } bk_state_t;

    // queue entry: {ctl, count, divisions, end_z, end_y, end_x}
    function automatic int entry_bits(input int coord_bits, input int count_bits);
        return $bits(cmd_ctl_t) + 2 * count_bits + AXES * coord_bits;
    endfunction

endpackage

`default_nettype wire

@@ sv/bzs_if.sv @@
`default_nettype none

interface bzs_in_if import bzs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;

    modport source (output valid, kind, end_x, end_y, end_z, input ready);
    modport sink   (input valid, kind, end_x, end_y, end_z, output ready);
endinterface

interface bzs_out_if import bzs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         moved;
    logic                         finished;

    modport source (output valid, pos_x, pos_y, pos_z, moved, finished, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, moved, finished, output ready);
endinterface

interface bzs_cfg_if import bzs_pkg::*; #(
    parameter int DATA_BITS = COORD_BITS_DEF
) ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/bzs_front.sv @@
`default_nettype none

module bzs_front import bzs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int ENTRY_BITS = entry_bits(COORD_BITS, COUNT_BITS)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bzs_in_if.sink                     in_ch,
    input  wire logic [COUNT_BITS-1:0] divisions,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output logic [ENTRY_BITS-1:0]      q_data
);

    logic [COUNT_BITS-1:0] step_count_reg, step_count_next;
    logic                  running_reg, running_next;
    logic [COUNT_BITS-1:0] d_eff;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  step_fin;
    logic                  accept;
    cmd_ctl_t              ctl;

    assign d_eff    = (divisions == '0) ? COUNT_BITS'(1) : divisions;
    assign cnt_inc  = step_count_reg + 1'b1;
    // counter wrap also ends the run
    assign step_fin = (cnt_inc == '0) || (cnt_inc >= d_eff);
    assign accept   = in_ch.valid && q_ready;

    always_comb
    begin
        ctl.op          = (!in_ch.kind && running_reg) ? CMD_STEP : CMD_ECHO;
        ctl.fin         = (ctl.op == CMD_STEP) && step_fin;
        step_count_next = step_count_reg;
        running_next    = running_reg;
        if (accept)
        begin
            if (in_ch.kind)
            begin
                step_count_next = '0;
                running_next    = 1'b1;
            end
            else if (running_reg)
            begin
                step_count_next = step_fin ? '0 : cnt_inc;
                running_next    = !step_fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= '0;
            running_reg    <= 1'b1;
        end
        else
        begin
            step_count_reg <= step_count_next;
            running_reg    <= running_next;
        end
    end

    assign in_ch.ready = q_ready;
    assign q_valid     = in_ch.valid;
    assign q_data      = {ctl, step_count_reg, d_eff, in_ch.end_z, in_ch.end_y, in_ch.end_x};

endmodule

`default_nettype wire

@@ sv/bzs_queue.sv @@
`default_nettype none

module bzs_queue import bzs_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                push, pop;

    assign in_ready  = (count_reg != CNT_BITS'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/bzs_back.sv @@
`default_nettype none

module bzs_back import bzs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int ENTRY_BITS = entry_bits(COORD_BITS, COUNT_BITS)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_valid,
    output logic                                    q_ready,
    input  wire logic [ENTRY_BITS-1:0]              q_data,
    input  wire logic [AXES-1:0][COORD_BITS-1:0]    start_pt,
    input  wire logic [AXES-1:0][COORD_BITS-1:0]    ctrl_pt,
    bzs_out_if.source                               out_ch
);

    localparam int CW   = COORD_BITS;
    localparam int CB   = COUNT_BITS;
    localparam int MW   = CB + 2;          // coefficient multiplier operand
    localparam int KW   = 2 * CB + 2;      // curve coefficient, signed
    localparam int PW   = KW + CW;         // coefficient times coordinate
    localparam int NUMW = PW + 2;          // sum of three products
    localparam int DSQW = 2 * CB;          // divisions squared
    localparam int SEQW = $clog2(NUMW);
    localparam int CTLW = $bits(cmd_ctl_t);

    localparam logic [SEQW-1:0] SEQ_LAST4 = SEQW'(3);
    localparam logic [SEQW-1:0] DIV_LAST  = SEQW'(NUMW - 1);
    localparam logic [NUMW-1:0] POS_LIM   = NUMW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [NUMW-1:0] NEG_LIM   = NUMW'(64'd1 << (CW - 1));
    localparam logic [CW-1:0]   COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]   COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // entry unpack
    cmd_ctl_t                   q_ctl;
    logic [CB-1:0]              q_count;
    logic [CB-1:0]              q_div;
    logic [AXES-1:0][CW-1:0]    q_end;

    assign q_ctl   = cmd_ctl_t'(q_data[AXES*CW + 2*CB +: CTLW]);
    assign q_count = q_data[AXES*CW + CB +: CB];
    assign q_div   = q_data[AXES*CW +: CB];
    assign q_end   = q_data[AXES*CW-1:0];

    bk_state_t                  state_reg, state_next;
    logic [SEQW-1:0]            seq_reg, seq_next;
    logic                       take_job, echo_load, res_load, out_free;

    logic                       out_valid_reg;
    logic [AXES-1:0][CW-1:0]    pos_reg;
    logic                       moved_reg, finished_reg;
    logic [AXES-1:0][CW-1:0]    held_reg;

    logic [CB-1:0]              c_reg, d_reg;
    logic                       fin_reg;
    logic [AXES-1:0][CW-1:0]    end_reg;
    logic signed [KW-1:0]       k_rr_reg, k_cr_reg, k_cc_reg;
    logic [DSQW-1:0]            dsq_reg;

    logic signed [PW-1:0]       prod_reg [AXES];
    logic signed [NUMW-1:0]     acc_reg  [AXES];
    logic [NUMW-1:0]            quo_reg  [AXES];
    logic [DSQW-1:0]            rem_reg  [AXES];
    logic                       neg_reg  [AXES];

    logic signed [CB:0]         r_val;
    logic signed [MW-1:0]       mul_a, mul_b;
    logic signed [2*MW-1:0]     kmul;
    logic signed [KW-1:0]       k_sel;
    logic signed [CW-1:0]       p_sel    [AXES];
    logic signed [PW-1:0]       prod_w   [AXES];
    logic [DSQW:0]              rem_sh   [AXES];
    logic [DSQW:0]              rem_diff [AXES];
    logic                       rem_ge   [AXES];
    logic [AXES-1:0][CW-1:0]    sat_w;

    assign out_free = !out_valid_reg || out_ch.ready;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            seq_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        seq_next   = seq_reg;
        q_ready    = 1'b0;
        take_job   = 1'b0;
        echo_load  = 1'b0;
        res_load   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                seq_next = '0;
                if (q_valid)
                begin
                    if (q_ctl.op == CMD_STEP)
                    begin
                        q_ready    = 1'b1;
                        take_job   = 1'b1;
                        state_next = BK_COEF;
                    end
                    else if (out_free)
                    begin
                        q_ready   = 1'b1;
                        echo_load = 1'b1;
                    end
                end
            end
            BK_COEF:
            begin
                seq_next = seq_reg + 1'b1;
                if (seq_reg == SEQ_LAST4)
                begin
                    seq_next   = '0;
                    state_next = BK_PROD;
                end
            end
            BK_PROD:
            begin
                seq_next = seq_reg + 1'b1;
                if (seq_reg == SEQ_LAST4)
                begin
                    seq_next   = '0;
                    state_next = BK_ABS;
                end
            end
            BK_ABS:
            begin
                seq_next   = '0;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                seq_next = seq_reg + 1'b1;
                if (seq_reg == DIV_LAST)
                begin
                    seq_next   = '0;
                    state_next = BK_SAT;
                end
            end
            BK_SAT:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
                seq_next   = '0;
            end
        endcase
    end

    // ---------------- coefficient multiplier ----------------
    assign r_val = $signed({1'b0, d_reg}) - $signed({1'b0, c_reg});

    always_comb
    begin
        case (seq_reg[1:0])
            2'd0:
            begin
                mul_a = {r_val[CB], r_val};
                mul_b = {r_val[CB], r_val};
            end
            2'd1:
            begin
                mul_a = $signed({2'b00, c_reg});
                mul_b = {r_val[CB], r_val};
            end
            2'd2:
            begin
                mul_a = $signed({2'b00, c_reg});
                mul_b = $signed({2'b00, c_reg});
            end
            default:
            begin
                mul_a = $signed({2'b00, d_reg});
                mul_b = $signed({2'b00, d_reg});
            end
        endcase
    end

    assign kmul = mul_a * mul_b;

    // ---------------- per-axis lanes ----------------
    always_comb
    begin
        case (seq_reg[1:0])
            2'd0:    k_sel = k_rr_reg;
            2'd1:    k_sel = k_cr_reg;
            default: k_sel = k_cc_reg;
        endcase
        for (int a = 0; a < AXES; a++)
        begin
            case (seq_reg[1:0])
                2'd0:    p_sel[a] = $signed(start_pt[a]);
                2'd1:    p_sel[a] = $signed(ctrl_pt[a]);
                default: p_sel[a] = $signed(end_reg[a]);
            endcase
            prod_w[a]   = k_sel * p_sel[a];
            rem_sh[a]   = {rem_reg[a], quo_reg[a][NUMW-1]};
            rem_diff[a] = rem_sh[a] - {1'b0, dsq_reg};
            rem_ge[a]   = (rem_sh[a] >= {1'b0, dsq_reg});
            if (!neg_reg[a])
            begin
                sat_w[a] = (quo_reg[a] > POS_LIM) ? COORD_MAX : quo_reg[a][CW-1:0];
            end
            else
            begin
                sat_w[a] = (quo_reg[a] > NEG_LIM) ? COORD_MIN : (~quo_reg[a][CW-1:0] + 1'b1);
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_job)
        begin
            c_reg   <= q_count;
            d_reg   <= q_div;
            fin_reg <= q_ctl.fin;
            end_reg <= q_end;
        end
        if (state_reg == BK_COEF)
        begin
            case (seq_reg[1:0])
                2'd0:    k_rr_reg <= kmul[KW-1:0];
                2'd1:    k_cr_reg <= {kmul[KW-2:0], 1'b0};
                2'd2:    k_cc_reg <= kmul[KW-1:0];
                default: dsq_reg  <= kmul[DSQW-1:0];
            endcase
        end
        for (int a = 0; a < AXES; a++)
        begin
            case (state_reg)
                BK_PROD:
                begin
                    prod_reg[a] <= prod_w[a];
                    if (seq_reg == '0)
                    begin
                        acc_reg[a] <= '0;
                    end
                    else
                    begin
                        acc_reg[a] <= acc_reg[a] + {{2{prod_reg[a][PW-1]}}, prod_reg[a]};
                    end
                end
                BK_ABS:
                begin
                    neg_reg[a] <= acc_reg[a][NUMW-1];
                    quo_reg[a] <= acc_reg[a][NUMW-1] ? (~acc_reg[a] + 1'b1) : acc_reg[a];
                    rem_reg[a] <= '0;
                end
                BK_DIV:
                begin
                    rem_reg[a] <= rem_ge[a] ? rem_diff[a][DSQW-1:0] : rem_sh[a][DSQW-1:0];
                    quo_reg[a] <= {quo_reg[a][NUMW-2:0], rem_ge[a]};
                end
                default:
                begin
                end
            endcase
        end
        if (echo_load)
        begin
            pos_reg      <= held_reg;
            moved_reg    <= 1'b0;
            finished_reg <= 1'b0;
        end
        else if (res_load)
        begin
            pos_reg      <= sat_w;
            moved_reg    <= 1'b1;
            finished_reg <= fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            if (echo_load || res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (res_load)
            begin
                held_reg <= sat_w;
            end
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.pos_x    = pos_reg[0];
    assign out_ch.pos_y    = pos_reg[1];
    assign out_ch.pos_z    = pos_reg[2];
    assign out_ch.moved    = moved_reg;
    assign out_ch.finished = finished_reg;

endmodule

`default_nettype wire

@@ sv/quadratic_bezier_stepper_unit.sv @@
// Quadratic Bezier stepper: one 3D curve point per advance beat.
// cfg_ch  : register writes (index 0..2 start point, 3..5 control point,
//           6 divisions). Always ready. Write only while the block is idle.
// in_ch   : kind = 0 advances one step (while armed) using the beat's end point,
//           kind = 1 rearms the curve at count zero.
// out_ch  : exactly one result beat per input beat, in order. pos is the
//           new point (moved = 1) or the held point (moved = 0); finished
//           flags the step that closed the run.
// Path    : an advance beat's result passes the queue, then the states
//           COEF, PROD, ABS, DIV and SAT, then the output register;
//           NUMW = 2*COUNT_BITS + COORD_BITS + 4 (40 at defaults). DIV is
//           a bit-serial divide by divisions squared, one quotient bit per
//           cycle, three axes in parallel lanes. Restart / idle beats pass
//           the queue and the output register when nothing waits ahead.
// Queue   : the back end takes one advance beat at a time; the two-entry
//           command queue keeps taking beats while the back end computes.
// Reset   : points clear to the origin, divisions = 16, count zero and
//           armed, held point at origin, output empty.
// Stall   : a result waits in the output register; the back end finishes
//           the next point behind it, then the queue fills and in_ch drops
//           ready.
`default_nettype none

module quadratic_bezier_stepper_unit import bzs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bzs_cfg_if.sink   cfg_ch,
    bzs_in_if.sink    in_ch,
    bzs_out_if.source out_ch
);

    localparam int ENTRY_BITS = entry_bits(COORD_BITS, COUNT_BITS);

    // configuration registers, [0] = x
    logic [AXES-1:0][COORD_BITS-1:0] start_reg;
    logic [AXES-1:0][COORD_BITS-1:0] ctrl_reg;
    logic [COUNT_BITS-1:0]           div_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            ctrl_reg  <= '0;
            div_reg   <= COUNT_BITS'(DIVISIONS_RESET);
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_reg_t'(cfg_ch.index))
                REG_START_X:   start_reg[0] <= cfg_ch.data[COORD_BITS-1:0];
                REG_START_Y:   start_reg[1] <= cfg_ch.data[COORD_BITS-1:0];
                REG_START_Z:   start_reg[2] <= cfg_ch.data[COORD_BITS-1:0];
                REG_CTRL_X:    ctrl_reg[0]  <= cfg_ch.data[COORD_BITS-1:0];
                REG_CTRL_Y:    ctrl_reg[1]  <= cfg_ch.data[COORD_BITS-1:0];
                REG_CTRL_Z:    ctrl_reg[2]  <= cfg_ch.data[COORD_BITS-1:0];
                REG_DIVISIONS: div_reg      <= cfg_ch.data[COUNT_BITS-1:0];
                default:
                begin
                    // unknown index: dropped
                end
            endcase
        end
    end

    // front end -> queue -> back end
    logic                  f_valid, f_ready;
    logic [ENTRY_BITS-1:0] f_data;
    logic                  b_valid, b_ready;
    logic [ENTRY_BITS-1:0] b_data;

    // front owns the step counter and run flag, so it classifies each beat
    // and decides "finished" at accept time
    bzs_front #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .divisions (div_reg),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_data    (f_data)
    );

    bzs_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    // back end: coefficients, per-axis products, divide, saturate, hold
    bzs_back #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_data   (b_data),
        .start_pt (start_reg),
        .ctrl_pt  (ctrl_reg),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

@@ sv/bzs_checker.sv @@
`default_nettype none

module bzs_checker import bzs_pkg::*; #(
    parameter int CW = COORD_BITS_DEF
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire logic [CW-1:0] pos_x,
    input wire logic [CW-1:0] pos_y,
    input wire logic [CW-1:0] pos_z,
    input wire logic          moved,
    input wire logic          finished
);

    // queue entries + one in the back end + the output register
    localparam int MAX_PEND  = QUEUE_DEPTH + 2;
    localparam int PEND_BITS = $clog2(MAX_PEND + 2);

    logic [PEND_BITS-1:0] pend_reg, pend_next;

    assign pend_next = pend_reg + PEND_BITS'(in_valid && in_ready)
                                - PEND_BITS'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({pos_x, pos_y, pos_z, moved, finished}))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result without an outstanding beat");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_BITS'(MAX_PEND))
        else $error("more beats in flight than storage");

    a_fin_moved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> moved)
        else $error("finished without a computed point");

endmodule

bind quadratic_bezier_stepper_unit bzs_checker #(
    .CW (COORD_BITS)
) u_bzs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .pos_x     (out_ch.pos_x),
    .pos_y     (out_ch.pos_y),
    .pos_z     (out_ch.pos_z),
    .moved     (out_ch.moved),
    .finished  (out_ch.finished)
);

`default_nettype wire
